### hw/rtl/segr_pkg.sv
package segr_pkg;

    localparam int CTR_MAX_W  = 6;
    localparam int LEN_W      = 10;
    localparam int CAP_W      = 10;
    localparam int TMO_W      = 16;
    localparam int IDX_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 4;

    localparam int DEF_BUFFER_DEPTH    = 512;
    localparam int DEF_COUNTER_MODULUS = 64;
    localparam int DEF_COUNTER_WIDTH   = 6;
    localparam int DEF_FIRST_FLAG_BIT  = 7;
    localparam int DEF_LAST_FLAG_BIT   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_EMPTY = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // ST_FRAGMENT doubles as the "segment still good" verdict
    typedef enum logic [2:0] {
        ST_FRAGMENT = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ORPHAN   = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_COUNTER  = 3'd6
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    // one request from the front to the back
    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_data;
        logic              has_out;
        t_kind             kind;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic              rd_hit;
    } t_cmd;

endpackage

### hw/rtl/segr_in_if.sv
interface segr_in_if import segr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] data_byte;
    logic              segment_end;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, operation, data_byte, segment_end, read_index,
                    input ready);
    modport sink   (input valid, operation, data_byte, segment_end, read_index,
                    output ready);
endinterface

### hw/rtl/segr_out_if.sv
interface segr_out_if import segr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [2:0]        status;
    logic [LEN_W-1:0]  assembled_length;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, result_kind, status, assembled_length, read_data,
                    input ready);
    modport sink   (input valid, result_kind, status, assembled_length, read_data,
                    output ready);
endinterface

### hw/rtl/segr_front.sv
module segr_front import segr_pkg::*; #(
    parameter int BUFFER_DEPTH    = DEF_BUFFER_DEPTH,
    parameter int COUNTER_MODULUS = DEF_COUNTER_MODULUS,
    parameter int COUNTER_WIDTH   = DEF_COUNTER_WIDTH,
    parameter int FIRST_FLAG_BIT  = DEF_FIRST_FLAG_BIT,
    parameter int LAST_FLAG_BIT   = DEF_LAST_FLAG_BIT,
    parameter int AW              = $clog2(DEF_BUFFER_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    segr_in_if.sink               seg,
    input  logic                  i_q_not_full,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [AW-1:0]         o_addr
);

    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = LW + 1;
    localparam int CW = (PW > CAP_W) ? PW : CAP_W;
    localparam int XW = ((LW > IDX_W) ? LW : IDX_W) + 1;

    function automatic logic [CTR_MAX_W-1:0] ctr_wrap(input logic [CTR_MAX_W:0] v);
        logic [CTR_MAX_W-1:0] r;
        r = '0;
        for (int i = 0; i < 2 ** (CTR_MAX_W + 1); i++) begin
            if (v == (CTR_MAX_W + 1)'(i)) begin
                r = CTR_MAX_W'(i % COUNTER_MODULUS);
            end
        end
        return r;
    endfunction

    logic [CAP_W-1:0]     r_capacity;
    logic [TMO_W-1:0]     r_timeout;
    logic [LW-1:0]        r_committed, n_committed;
    logic [LW-1:0]        r_pending, n_pending;
    logic                 r_header_next, n_header_next;
    logic                 r_in_progress, n_in_progress;
    logic [CTR_MAX_W-1:0] r_expected, n_expected;
    logic [TMO_W-1:0]     r_deadline, n_deadline;
    t_status              r_verdict, n_verdict;
    logic                 r_first, n_first;
    logic                 r_last, n_last;
    logic [CTR_MAX_W-1:0] r_ctr, n_ctr;

    logic          accept;
    t_op           op;
    logic [CW-1:0] cap_eff;
    logic [PW-1:0] pos;
    logic [PW-1:0] new_len;

    assign seg.ready = i_q_not_full;
    assign accept    = seg.valid && seg.ready;
    assign op        = t_op'(seg.operation);

    always_comb begin
        if (CW'(r_capacity) < CW'(BUFFER_DEPTH)) begin
            cap_eff = CW'(r_capacity);
        end else begin
            cap_eff = CW'(BUFFER_DEPTH);
        end
    end

    always_comb begin
        n_committed   = r_committed;
        n_pending     = r_pending;
        n_header_next = r_header_next;
        n_in_progress = r_in_progress;
        n_expected    = r_expected;
        n_deadline    = r_deadline;
        n_verdict     = r_verdict;
        n_first       = r_first;
        n_last        = r_last;
        n_ctr         = r_ctr;
        o_push        = 1'b0;
        o_cmd         = '0;
        o_addr        = '0;
        pos           = (r_first ? PW'(0) : PW'(r_committed)) + PW'(r_pending);
        new_len       = '0;

        if (accept) begin
            unique case (op)
                OP_TICK: begin
                    if (r_deadline != '0) begin
                        n_deadline = r_deadline - 1'b1;
                    end
                end
                OP_READ: begin
                    o_push         = 1'b1;
                    o_cmd.has_out  = 1'b1;
                    o_cmd.kind     = KIND_READ;
                    o_cmd.status   = ST_FRAGMENT;
                    o_cmd.length   = LEN_W'(r_committed);
                    o_cmd.rd_hit   = (XW'(seg.read_index) < XW'(r_committed)) &&
                                     (XW'(seg.read_index) < XW'(BUFFER_DEPTH));
                    o_addr         = AW'(seg.read_index);
                end
                OP_EMPTY: begin
                    n_header_next = 1'b1;
                    n_pending     = '0;
                    o_push        = 1'b1;
                    o_cmd.has_out = 1'b1;
                    o_cmd.kind    = KIND_STATUS;
                    o_cmd.status  = ST_LENGTH;
                    o_cmd.length  = LEN_W'(r_committed);
                end
                OP_BYTE: begin
                    if (r_header_next) begin
                        n_first       = seg.data_byte[FIRST_FLAG_BIT];
                        n_last        = seg.data_byte[LAST_FLAG_BIT];
                        n_ctr         = CTR_MAX_W'(seg.data_byte[COUNTER_WIDTH-1:0]);
                        n_pending     = '0;
                        n_header_next = 1'b0;
                        priority if (n_first) begin
                            n_verdict = ST_FRAGMENT;
                        end else if (!r_in_progress) begin
                            n_verdict = ST_ORPHAN;
                        end else if (r_deadline == '0) begin
                            n_verdict = ST_TIMEOUT;
                        end else if (n_ctr != r_expected) begin
                            n_verdict = ST_COUNTER;
                        end else begin
                            n_verdict = ST_FRAGMENT;
                        end
                    end else if (r_verdict == ST_FRAGMENT) begin
                        if (CW'(pos) < cap_eff) begin
                            o_push        = 1'b1;
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_data = seg.data_byte;
                            o_addr        = AW'(pos);
                            n_pending     = r_pending + 1'b1;
                        end else begin
                            n_verdict = ST_OVERFLOW;
                        end
                    end

                    if (seg.segment_end) begin
                        n_header_next = 1'b1;
                        new_len = (n_first ? PW'(0) : PW'(r_committed)) + PW'(n_pending);
                        o_push        = 1'b1;
                        o_cmd.has_out = 1'b1;
                        o_cmd.kind    = KIND_STATUS;
                        o_cmd.status  = n_verdict;
                        if (n_verdict == ST_FRAGMENT) begin
                            n_committed = LW'(new_len);
                            if (n_last) begin
                                n_in_progress = 1'b0;
                                o_cmd.status  = ST_COMPLETE;
                            end else begin
                                n_in_progress = 1'b1;
                                n_expected    = ctr_wrap({1'b0, n_ctr} + 1'b1);
                                n_deadline    = r_timeout;
                            end
                        end else if (n_verdict != ST_ORPHAN) begin
                            n_committed   = '0;
                            n_in_progress = 1'b0;
                        end
                        n_pending    = '0;
                        o_cmd.length = LEN_W'(n_committed);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= CAP_RESET;
            r_timeout     <= TMO_RESET;
            r_committed   <= '0;
            r_pending     <= '0;
            r_header_next <= 1'b1;
            r_in_progress <= 1'b0;
            r_expected    <= '0;
            r_deadline    <= '0;
            r_verdict     <= ST_FRAGMENT;
            r_first       <= 1'b0;
            r_last        <= 1'b0;
            r_ctr         <= '0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index == CFG_CAPACITY) begin
                r_capacity <= i_cfg_data[CAP_W-1:0];
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[TMO_W-1:0];
            end
            r_committed   <= n_committed;
            r_pending     <= n_pending;
            r_header_next <= n_header_next;
            r_in_progress <= n_in_progress;
            r_expected    <= n_expected;
            r_deadline    <= n_deadline;
            r_verdict     <= n_verdict;
            r_first       <= n_first;
            r_last        <= n_last;
            r_ctr         <= n_ctr;
        end
    end

endmodule

### hw/rtl/segr_queue.sv
module segr_queue import segr_pkg::*; #(
    parameter int AW    = $clog2(DEF_BUFFER_DEPTH),
    parameter int DEPTH = Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_not_full,
    output logic          o_valid,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd          r_cmd  [DEPTH];
    logic [AW-1:0] r_addr [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_not_full = (r_count != CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;
    assign o_cmd      = r_cmd[r_rd_ptr];
    assign o_addr     = r_addr[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

### hw/rtl/segr_back.sv
module segr_back import segr_pkg::*; #(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int AW           = $clog2(DEF_BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_pop,
    segr_out_if.source    res
);

    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rd_q;

    logic              r_a_valid;
    t_kind             r_a_kind;
    t_status           r_a_status;
    logic [LEN_W-1:0]  r_a_length;
    logic              r_a_hit;

    logic              r_o_valid;
    t_kind             r_o_kind;
    t_status           r_o_status;
    logic [LEN_W-1:0]  r_o_length;
    logic [BYTE_W-1:0] r_o_data;

    logic out_can, a_can;

    assign out_can = !r_o_valid || res.ready;
    assign a_can   = !r_a_valid || out_can;
    assign o_pop   = i_q_valid && a_can;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr_en) begin
            r_mem[i_addr] <= i_cmd.wr_data;
        end
        if (o_pop) begin
            r_rd_q <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_kind   <= i_cmd.kind;
            r_a_status <= i_cmd.status;
            r_a_length <= i_cmd.length;
            r_a_hit    <= i_cmd.rd_hit;
        end
        if (out_can && r_a_valid) begin
            r_o_kind   <= r_a_kind;
            r_o_status <= r_a_status;
            r_o_length <= r_a_length;
            r_o_data   <= (r_a_kind == KIND_READ && r_a_hit) ? r_rd_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_can) begin
                r_a_valid <= o_pop && i_cmd.has_out;
            end
            if (out_can) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    assign res.valid            = r_o_valid;
    assign res.result_kind      = r_o_kind;
    assign res.status           = r_o_status;
    assign res.assembled_length = r_o_length;
    assign res.read_data        = r_o_data;

endmodule

### hw/rtl/segment_reassembler_core.sv
// channel   | dir | handshake     | payload
// ----------+-----+---------------+----------------------------------------------
// i_seg     | in  | valid/ready   | operation, data_byte, segment_end, read_index
// o_res     | out | valid/ready   | result_kind, status, assembled_length, read_data
// i_cfg_*   | in  | write enable  | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the queue is not full; an accepted request
// passes through the queue, the back's A stage and its output register to o_res.
// The front updates all segment state in the accepting cycle; buffer writes and
// reads go through a 4-entry queue to the back, whose memory read is registered.
// Synchronous active-low reset; the buffer memory is not cleared.
// i_seg.ready drops only while the queue is full, i.e. after o_res stalls.
module segment_reassembler_core import segr_pkg::*; #(
    parameter int BUFFER_DEPTH    = DEF_BUFFER_DEPTH,
    parameter int COUNTER_MODULUS = DEF_COUNTER_MODULUS,
    parameter int COUNTER_WIDTH   = DEF_COUNTER_WIDTH,
    parameter int FIRST_FLAG_BIT  = DEF_FIRST_FLAG_BIT,
    parameter int LAST_FLAG_BIT   = DEF_LAST_FLAG_BIT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    segr_in_if.sink               i_seg,
    segr_out_if.source            o_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          push, q_not_full, q_valid, pop;
    t_cmd          push_cmd, q_cmd;
    logic [AW-1:0] push_addr, q_addr;

    segr_front #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .COUNTER_MODULUS (COUNTER_MODULUS),
        .COUNTER_WIDTH   (COUNTER_WIDTH),
        .FIRST_FLAG_BIT  (FIRST_FLAG_BIT),
        .LAST_FLAG_BIT   (LAST_FLAG_BIT),
        .AW              (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .seg          (i_seg),
        .i_q_not_full (q_not_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_addr       (push_addr)
    );

    segr_queue #(
        .AW    (AW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_addr     (push_addr),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .i_pop      (pop),
        .o_cmd      (q_cmd),
        .o_addr     (q_addr)
    );

    segr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .i_addr    (q_addr),
        .o_pop     (pop),
        .res       (o_res)
    );

endmodule

### hw/rtl/segr_checker.sv
module segr_checker import segr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [2:0]        i_out_status,
    input logic [LEN_W-1:0]  i_out_length,
    input logic [BYTE_W-1:0] i_out_data
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_READ |-> i_out_status == ST_FRAGMENT)
        else $error("read reply carries a status");

    a_status_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_STATUS |-> i_out_data == '0)
        else $error("segment status carries data");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_READ && i_out_length == '0 |-> i_out_data == '0)
        else $error("read of empty buffer returned data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status != 3'd7)
        else $error("undefined status code");

endmodule

bind segment_reassembler_core segr_checker u_segr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_kind   (o_res.result_kind),
    .i_out_status (o_res.status),
    .i_out_length (o_res.assembled_length),
    .i_out_data   (o_res.read_data)
);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import segr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
    } t_reply;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    segr_in_if  seg_if ();
    segr_out_if res_if ();

    segment_reassembler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_seg       (seg_if),
        .o_res       (res_if)
    );

    // reassembly state as the block should hold it
    bit [BYTE_W-1:0] buf_mem [DEF_BUFFER_DEPTH];
    int unsigned     held_len     = 0;
    int unsigned     seg_fill     = 0;
    bit              await_header = 1'b1;
    bit              msg_open     = 1'b0;
    int unsigned     next_ctr     = 0;
    int unsigned     ticks_left   = 0;
    t_status         seg_verdict  = ST_FRAGMENT;
    bit              seg_first    = 1'b0;
    bit              seg_last     = 1'b0;
    int unsigned     seg_ctr      = 0;
    int unsigned     cap_setting  = CAP_RESET;
    int unsigned     tmo_setting  = TMO_RESET;

    t_reply      awaited_replies [$];
    int unsigned sent_total = 0;
    int unsigned failures = 0;
    bit          idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_reply(t_op op, logic [BYTE_W-1:0] b, logic e,
                                 logic [IDX_W-1:0] idx);
        t_reply      r;
        int unsigned pos;
        int unsigned limit;
        t_status     st;
        r = '{kind: KIND_STATUS, status: ST_FRAGMENT, length: '0, data: '0};
        limit = (cap_setting < DEF_BUFFER_DEPTH) ? cap_setting : DEF_BUFFER_DEPTH;
        case (op)
            OP_TICK: begin
                if (ticks_left != 0) ticks_left--;
                return;
            end
            OP_READ: begin
                r.kind   = KIND_READ;
                r.length = LEN_W'(held_len);
                r.data   = (idx < held_len) ? buf_mem[idx] : '0;
            end
            OP_EMPTY: begin
                await_header = 1'b1;
                seg_fill     = 0;
                r.status     = ST_LENGTH;
                r.length     = LEN_W'(held_len);
            end
            default: begin
                if (await_header) begin
                    seg_first    = b[DEF_FIRST_FLAG_BIT];
                    seg_last     = b[DEF_LAST_FLAG_BIT];
                    seg_ctr      = b & ((1 << DEF_COUNTER_WIDTH) - 1);
                    seg_fill     = 0;
                    await_header = 1'b0;
                    if (seg_first) seg_verdict = ST_FRAGMENT;
                    else if (!msg_open) seg_verdict = ST_ORPHAN;
                    else if (ticks_left == 0) seg_verdict = ST_TIMEOUT;
                    else if (seg_ctr != next_ctr) seg_verdict = ST_COUNTER;
                    else seg_verdict = ST_FRAGMENT;
                end else if (seg_verdict == ST_FRAGMENT) begin
                    pos = (seg_first ? 0 : held_len) + seg_fill;
                    if (pos < limit) begin
                        buf_mem[pos] = b;
                        seg_fill++;
                    end else begin
                        seg_verdict = ST_OVERFLOW;
                    end
                end
                if (!e) return;
                st = seg_verdict;
                await_header = 1'b1;
                if (st == ST_FRAGMENT) begin
                    held_len = (seg_first ? 0 : held_len) + seg_fill;
                    if (seg_last) begin
                        msg_open = 1'b0;
                        st = ST_COMPLETE;
                    end else begin
                        msg_open   = 1'b1;
                        next_ctr   = (seg_ctr + 1) % DEF_COUNTER_MODULUS;
                        ticks_left = tmo_setting;
                    end
                end else if (st != ST_ORPHAN) begin
                    held_len = 0;
                    msg_open = 1'b0;
                end
                seg_fill = 0;
                r.status = st;
                r.length = LEN_W'(held_len);
            end
        endcase
        awaited_replies.push_back(r);
    endtask

    task automatic send_req(t_op op, logic [BYTE_W-1:0] b, logic e, logic [IDX_W-1:0] idx);
        while (idle_on && $urandom_range(99) < 9) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_if.valid       <= 1'b1;
        seg_if.operation   <= op;
        seg_if.data_byte   <= b;
        seg_if.segment_end <= e;
        seg_if.read_index  <= idx;
        do @(posedge i_clk); while (seg_if.ready !== 1'b1);
        predict_reply(op, b, e, idx);
        sent_total++;
    endtask

    // drain outstanding replies, then let the pipeline empty
    task automatic settle();
        seg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(int unsigned cap, int unsigned tmo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= CFG_DATA_W'(cap);
        @(posedge i_clk);
        cap_setting = cap & 10'h3FF;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(tmo);
        @(posedge i_clk);
        tmo_setting = tmo & 16'hFFFF;
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if (held_len != 0 && $urandom_range(99) < 70)
            return (held_len > 511) ? IDX_W'($urandom_range(511))
                                    : IDX_W'($urandom_range(held_len));
        return IDX_W'($urandom);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 90) return $urandom_range(1, 6);
        return $urandom_range(7, 40);
    endfunction

    task automatic send_side_traffic();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) send_req(OP_TICK, BYTE_W'($urandom), 1'($urandom), IDX_W'($urandom));
        else if (r < 10) send_req(OP_READ, BYTE_W'($urandom), 1'($urandom), pick_index());
    endtask

    task automatic send_segment(bit first, bit last, logic [DEF_COUNTER_WIDTH-1:0] ctr,
                                int unsigned n, bit mixed);
        logic [BYTE_W-1:0] hdr;
        hdr = '0;
        hdr[DEF_FIRST_FLAG_BIT] = first;
        hdr[DEF_LAST_FLAG_BIT]  = last;
        hdr[DEF_COUNTER_WIDTH-1:0] = ctr;
        send_req(OP_BYTE, hdr, n == 0, IDX_W'($urandom));
        for (int i = 0; i < n; i++) begin
            if (mixed) begin
                send_side_traffic();
                // abandon the segment part way through
                if ($urandom_range(99) < 2) begin
                    send_req(OP_EMPTY, BYTE_W'($urandom), 1'($urandom), IDX_W'($urandom));
                    return;
                end
            end
            send_req(OP_BYTE, BYTE_W'($urandom), i == n - 1, IDX_W'($urandom));
        end
    endtask

    task automatic send_random_message();
        int unsigned nseg;
        bit          first;
        logic [DEF_COUNTER_WIDTH-1:0] ctr;
        logic [DEF_COUNTER_WIDTH-1:0] c;
        nseg = $urandom_range(1, 4);
        ctr  = DEF_COUNTER_WIDTH'($urandom);
        for (int s = 0; s < nseg; s++) begin
            first = (s == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 3);
            c = ($urandom_range(99) < 6) ? DEF_COUNTER_WIDTH'($urandom) : ctr;
            send_segment(first, s == nseg - 1, c, pick_len(), 1'b1);
            ctr++;
            if (s < nseg - 1 && $urandom_range(99) < 25)
                repeat ($urandom_range(0, 6))
                    send_req(OP_TICK, BYTE_W'($urandom), 1'($urandom), IDX_W'($urandom));
        end
    endtask

    task automatic test_after_reset();
        send_req(OP_READ, 8'hFF, 1'b1, 9'd0);
        send_req(OP_TICK, 8'h00, 1'b0, 9'h1FF);
        send_req(OP_BYTE, 8'h05, 1'b1, 9'd0);
        send_req(OP_EMPTY, 8'hFF, 1'b0, 9'h1FF);
    endtask

    task automatic test_message_paths();
        send_req(OP_BYTE, 8'hC0, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'hFF, 1'b0, 9'h1FF);
        send_req(OP_BYTE, 8'h00, 1'b1, 9'd0);
        send_req(OP_READ, 8'h00, 1'b0, 9'd1);
        send_req(OP_READ, 8'hFF, 1'b1, 9'h1FF);
        // counter wraps from 63 to 0
        send_req(OP_BYTE, 8'hBF, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'hA5, 1'b1, 9'd0);
        send_req(OP_BYTE, 8'h40, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'h5A, 1'b1, 9'd0);
        // segment dropped by an empty request
        send_req(OP_BYTE, 8'h80, 1'b0, 9'd0);
        send_req(OP_EMPTY, 8'h00, 1'b1, 9'd0);
        // header-only fragment, then a bad counter
        send_req(OP_BYTE, 8'h80, 1'b1, 9'd0);
        send_req(OP_BYTE, 8'h05, 1'b1, 9'd0);
    endtask

    task automatic test_tight_limits();
        settle();
        write_cfg(1, 0);
        send_req(OP_BYTE, 8'h80, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'h11, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'h22, 1'b1, 9'd0);
        send_req(OP_BYTE, 8'h80, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'h33, 1'b1, 9'd0);
        send_req(OP_TICK, 8'h00, 1'b0, 9'd0);
        send_req(OP_BYTE, 8'h01, 1'b1, 9'd0);
    endtask

    task automatic test_full_buffer();
        settle();
        write_cfg(512, 65535);
        for (int s = 0; s < 4; s++)
            send_segment(s == 0, 1'b0, DEF_COUNTER_WIDTH'(s), 128, 1'b0);
        send_req(OP_READ, BYTE_W'($urandom), 1'($urandom), 9'd511);
        send_req(OP_READ, BYTE_W'($urandom), 1'($urandom), 9'd0);
        send_req(OP_READ, BYTE_W'($urandom), 1'($urandom), IDX_W'($urandom));
        send_segment(1'b0, 1'b0, DEF_COUNTER_WIDTH'(4), 1, 1'b0);
    endtask

    task automatic test_random_traffic(int unsigned cap, int unsigned tmo, int unsigned n,
                                       bit quiet);
        int unsigned stop_at;
        int unsigned r;
        settle();
        write_cfg(cap, tmo);
        idle_on = !quiet;
        stop_at = sent_total + n;
        while (sent_total < stop_at) begin
            r = $urandom_range(99);
            if (r < 75) begin
                send_random_message();
            end else if (r < 90) begin
                send_req(t_op'($urandom_range(3)), BYTE_W'($urandom), 1'($urandom),
                         IDX_W'($urandom));
            end else if (r < 97) begin
                send_req(OP_READ, BYTE_W'($urandom), 1'($urandom), pick_index());
            end else begin
                repeat ($urandom_range(1, 8))
                    send_req(OP_TICK, BYTE_W'($urandom), 1'($urandom), IDX_W'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            res_if.ready <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected reply: kind %0d status %0d length %0d data %0d",
                       res_if.result_kind, res_if.status, res_if.assembled_length,
                       res_if.read_data);
                failures++;
            end else begin
                want = awaited_replies.pop_front();
                if (res_if.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d actual %0d", want.kind,
                           res_if.result_kind);
                    failures++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, res_if.status);
                    failures++;
                end
                if (res_if.assembled_length !== want.length) begin
                    $error("assembled_length: expected %0d actual %0d", want.length,
                           res_if.assembled_length);
                    failures++;
                end
                if (res_if.read_data !== want.data) begin
                    $error("read_data: expected %0d actual %0d", want.data,
                           res_if.read_data);
                    failures++;
                end
            end
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_CAPACITY;
        cfg_data           <= '0;
        seg_if.valid       <= 1'b0;
        seg_if.operation   <= OP_TICK;
        seg_if.data_byte   <= '0;
        seg_if.segment_end <= 1'b0;
        seg_if.read_index  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_message_paths();
        test_tight_limits();
        test_full_buffer();
        test_random_traffic(512, 1000, 120, 1'b0);
        test_random_traffic(16, 3, 130, 1'b0);
        test_random_traffic(0, 5, 80, 1'b0);
        test_random_traffic(40, 4, 200, 1'b1);
        test_random_traffic(1023, 65535, 70, 1'b0);
        test_random_traffic(1, 0, 60, 1'b0);
        test_random_traffic($urandom_range(1, 64), $urandom_range(0, 8), 120, 1'b0);
        settle();

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hw/rtl/segr_pkg.sv
hw/rtl/segr_in_if.sv
hw/rtl/segr_out_if.sv
hw/rtl/segr_front.sv
hw/rtl/segr_queue.sv
hw/rtl/segr_back.sv
hw/rtl/segment_reassembler_core.sv
hw/rtl/segr_checker.sv
tb/testbench.sv
